// ----- rtl/assert_macros.svh -----
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked at every rising aclk edge, masked while reset is held
`define ASSERT_CLKD(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// checked at every rising aclk edge, reset included
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) (prop)) \
        else $error(msg);

`endif

// ----- rtl/thlr_pkg.sv -----
// types, widths and constants of the lightness remap pipeline
package thlr_pkg;

    localparam int FRAC_BITS = 16;
    localparam int QW        = FRAC_BITS + 1;
    localparam int NUMW      = 2 * QW;

    localparam logic [QW-1:0] FX_ONE        = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [QW-1:0] FX_HALF       = FX_ONE >> 1;
    localparam logic [QW-1:0] FX_SIXTH      = QW'((2 ** FRAC_BITS) / 6);
    localparam logic [QW-1:0] FX_THIRD      = QW'((2 ** FRAC_BITS) / 3);
    localparam logic [QW-1:0] FX_TWO_THIRDS = QW'((2 * (2 ** FRAC_BITS)) / 3);

    localparam int LIGHT_DEN = 510;

    // lightness by reciprocal multiply: sum * ceil(2^(F+SH)/510) >> SH, exact for sum <= 510
    localparam int LIGHT_SH = 20;
    localparam int RECIP_W  = FRAC_BITS + 12;
    localparam logic [RECIP_W-1:0] LIGHT_RECIP =
        RECIP_W'(((64'd1 << (FRAC_BITS + LIGHT_SH)) + 64'd509) / 64'd510);

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_THEME = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HALO  = 1'b1;

    localparam logic [15:0] THEME_RESET = 16'd65535;
    localparam logic [15:0] HALO_RESET  = 16'd63223;

    typedef struct packed {
        logic          grey;
        logic          upper;
        logic          kfull;
        logic [QW-1:0] light;
        logic [QW-1:0] sat;
        logic [QW-1:0] hue;
    } tag_t;

    typedef struct packed {
        logic          grey;
        logic [QW-1:0] nl;
        logic [QW-1:0] sat;
        logic [QW-1:0] hue;
    } pix_t;

    // q0.16 register value to internal fixed point
    function automatic logic [QW-1:0] q16_to_fx(input logic [15:0] v);
        logic [16+FRAC_BITS-1:0] w;
        w = {v, {FRAC_BITS{1'b0}}} >> 16;
        return w[QW-1:0];
    endfunction

endpackage

// ----- rtl/thlr_div.sv -----
// pipelined restoring divider, one quotient bit per stage
module thlr_div (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       ce,
    input  logic                       in_valid,
    input  logic [thlr_pkg::NUMW-1:0]  in_num,
    input  logic [thlr_pkg::QW-1:0]    in_den,
    input  thlr_pkg::tag_t             in_tag,
    output logic                       out_valid,
    output logic [thlr_pkg::QW-1:0]    out_quot,
    output thlr_pkg::tag_t             out_tag
);

    logic                      valid_reg [thlr_pkg::QW];
    logic [thlr_pkg::NUMW-1:0] rem_reg   [thlr_pkg::QW];
    logic [thlr_pkg::QW-1:0]   den_reg   [thlr_pkg::QW];
    logic [thlr_pkg::QW-1:0]   quot_reg  [thlr_pkg::QW];
    thlr_pkg::tag_t            tag_reg   [thlr_pkg::QW];

    for (genvar gi = 0; gi < thlr_pkg::QW; gi++) begin : g_stage
        localparam int SH = thlr_pkg::QW - 1 - gi;
        logic                      valid_prev;
        logic [thlr_pkg::NUMW-1:0] rem_prev;
        logic [thlr_pkg::QW-1:0]   den_prev;
        logic [thlr_pkg::QW-1:0]   quot_prev;
        thlr_pkg::tag_t            tag_prev;
        logic [thlr_pkg::NUMW-1:0] den_sh;
        logic                      fits;
        logic [thlr_pkg::NUMW-1:0] rem_next;
        logic [thlr_pkg::QW-1:0]   quot_next;

        if (gi == 0) begin : g_first
            assign valid_prev = in_valid;
            assign rem_prev   = in_num;
            assign den_prev   = in_den;
            assign quot_prev  = '0;
            assign tag_prev   = in_tag;
        end else begin : g_chain
            assign valid_prev = valid_reg[gi-1];
            assign rem_prev   = rem_reg[gi-1];
            assign den_prev   = den_reg[gi-1];
            assign quot_prev  = quot_reg[gi-1];
            assign tag_prev   = tag_reg[gi-1];
        end

        // trial subtract of the divisor at this bit weight
        assign den_sh    = thlr_pkg::NUMW'(den_prev) << SH;
        assign fits      = (rem_prev >= den_sh);
        assign rem_next  = fits ? (rem_prev - den_sh) : rem_prev;
        assign quot_next = {quot_prev[thlr_pkg::QW-2:0], fits};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[gi] <= 1'b0;
            end else if (ce) begin
                valid_reg[gi] <= valid_prev;
            end
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                rem_reg[gi]  <= rem_next;
                den_reg[gi]  <= den_prev;
                quot_reg[gi] <= quot_next;
                tag_reg[gi]  <= tag_prev;
            end
        end
    end

    assign out_valid = valid_reg[thlr_pkg::QW-1];
    assign out_quot  = quot_reg[thlr_pkg::QW-1];
    assign out_tag   = tag_reg[thlr_pkg::QW-1];

endmodule

// ----- rtl/thlr_rgb_out.sv -----
// hsl back to rgb, five stages ending in the output register
module thlr_rgb_out (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           ce,
    input  logic           in_valid,
    input  thlr_pkg::pix_t in_pix,
    output logic           out_valid,
    output logic [7:0]     out_red,
    output logic [7:0]     out_green,
    output logic [7:0]     out_blue,
    output logic           out_grey
);

    localparam int F  = thlr_pkg::FRAC_BITS;
    localparam int QW = thlr_pkg::QW;
    localparam int MW = 2 * QW + 1;
    localparam int PW = F + 3;
    localparam int FW = F + 4;
    localparam int XW = PW + FW;
    localparam int VW = F + 8;
    localparam int BW = VW + 8;

    localparam logic [1:0] SEG_RISE = 2'd0;
    localparam logic [1:0] SEG_HIGH = 2'd1;
    localparam logic [1:0] SEG_FALL = 2'd2;
    localparam logic [1:0] SEG_LOW  = 2'd3;

    // stage 6: lightness times the chroma factor
    logic          v6_reg;
    logic [MW-1:0] prod6_reg, prod6_next;
    logic [QW-1:0] nl6_reg, s6_reg, h6_reg;
    logic          grey6_reg, lt6_reg, lt6_next;
    logic [QW:0]   mfac;

    assign lt6_next   = (in_pix.nl < thlr_pkg::FX_HALF);
    assign mfac       = lt6_next ? ((QW+1)'(thlr_pkg::FX_ONE) + (QW+1)'(in_pix.sat))
                                 : (QW+1)'(in_pix.sat);
    assign prod6_next = MW'(in_pix.nl) * MW'(mfac);

    // stage 7: q, p and the three hue offsets
    logic          v7_reg;
    logic [PW-1:0] p7_reg, q7_reg, diff7_reg;
    logic [QW-1:0] t7_reg [3];
    logic [QW-1:0] nl7_reg;
    logic          grey7_reg;
    logic [PW-1:0] pshift, qv, two_nl, pv, diff_next;
    logic [QW:0]   tr_sum;
    logic [QW-1:0] t_next [3];

    always_comb begin
        pshift = PW'(prod6_reg >> F);
        if (lt6_reg) begin
            qv = pshift;
        end else begin
            qv = PW'(nl6_reg) + PW'(s6_reg) - pshift;
        end
        two_nl    = PW'(nl6_reg) << 1;
        pv        = (two_nl < qv) ? '0 : (two_nl - qv);
        diff_next = (qv > pv) ? (qv - pv) : '0;
        tr_sum    = (QW+1)'(h6_reg) + (QW+1)'(thlr_pkg::FX_THIRD);
        if (tr_sum > (QW+1)'(thlr_pkg::FX_ONE)) begin
            t_next[0] = QW'(tr_sum - (QW+1)'(thlr_pkg::FX_ONE));
        end else begin
            t_next[0] = QW'(tr_sum);
        end
        t_next[1] = h6_reg;
        if (h6_reg < thlr_pkg::FX_THIRD) begin
            t_next[2] = h6_reg + thlr_pkg::FX_ONE - thlr_pkg::FX_THIRD;
        end else begin
            t_next[2] = h6_reg - thlr_pkg::FX_THIRD;
        end
    end

    // stage 8: segment of the hue ramp and its slope product per channel
    logic          v8_reg;
    logic [XW-1:0] prod8_reg [3];
    logic [1:0]    seg8_reg  [3];
    logic [PW-1:0] p8_reg, q8_reg;
    logic [QW-1:0] nl8_reg;
    logic          grey8_reg;
    logic [FW-1:0] fac    [3];
    logic [1:0]    seg_next [3];
    logic [XW-1:0] prod8_next [3];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            if (t7_reg[c] < thlr_pkg::FX_SIXTH) begin
                seg_next[c] = SEG_RISE;
                fac[c]      = FW'(t7_reg[c]) * FW'(6);
            end else if (t7_reg[c] < thlr_pkg::FX_HALF) begin
                seg_next[c] = SEG_HIGH;
                fac[c]      = '0;
            end else if (t7_reg[c] < thlr_pkg::FX_TWO_THIRDS) begin
                seg_next[c] = SEG_FALL;
                fac[c]      = FW'(thlr_pkg::FX_TWO_THIRDS - t7_reg[c]) * FW'(6);
            end else begin
                seg_next[c] = SEG_LOW;
                fac[c]      = '0;
            end
            prod8_next[c] = XW'(diff7_reg) * XW'(fac[c]);
        end
    end

    // stage 9: channel value
    logic          v9_reg;
    logic [VW-1:0] val9_reg [3];
    logic          grey9_reg;
    logic [VW-1:0] val_next [3];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            case (seg8_reg[c])
                SEG_RISE, SEG_FALL: val_next[c] = VW'(p8_reg) + VW'(prod8_reg[c] >> F);
                SEG_HIGH:           val_next[c] = VW'(q8_reg);
                SEG_LOW:            val_next[c] = VW'(p8_reg);
                default:            val_next[c] = VW'(p8_reg);
            endcase
            if (grey8_reg) begin
                val_next[c] = VW'(nl8_reg);
            end
        end
    end

    // stage 10: scale to a byte and saturate
    logic          v10_reg;
    logic [7:0]    byte10_reg [3];
    logic          grey10_reg;
    logic [BW-1:0] scaled [3];
    logic [7:0]    byte_next [3];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            scaled[c]    = (BW'(val9_reg[c]) * BW'(255)) >> F;
            byte_next[c] = (scaled[c] > BW'(255)) ? 8'd255 : scaled[c][7:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v6_reg  <= 1'b0;
            v7_reg  <= 1'b0;
            v8_reg  <= 1'b0;
            v9_reg  <= 1'b0;
            v10_reg <= 1'b0;
        end else if (ce) begin
            v6_reg  <= in_valid;
            v7_reg  <= v6_reg;
            v8_reg  <= v7_reg;
            v9_reg  <= v8_reg;
            v10_reg <= v9_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            prod6_reg  <= prod6_next;
            nl6_reg    <= in_pix.nl;
            s6_reg     <= in_pix.sat;
            h6_reg     <= in_pix.hue;
            grey6_reg  <= in_pix.grey;
            lt6_reg    <= lt6_next;

            p7_reg     <= pv;
            q7_reg     <= qv;
            diff7_reg  <= diff_next;
            nl7_reg    <= nl6_reg;
            grey7_reg  <= grey6_reg;

            p8_reg     <= p7_reg;
            q8_reg     <= q7_reg;
            nl8_reg    <= nl7_reg;
            grey8_reg  <= grey7_reg;

            grey9_reg  <= grey8_reg;
            grey10_reg <= grey9_reg;

            for (int c = 0; c < 3; c++) begin
                t7_reg[c]     <= t_next[c];
                prod8_reg[c]  <= prod8_next[c];
                seg8_reg[c]   <= seg_next[c];
                val9_reg[c]   <= val_next[c];
                byte10_reg[c] <= byte_next[c];
            end
        end
    end

    assign out_valid = v10_reg;
    assign out_red   = byte10_reg[0];
    assign out_green = byte10_reg[1];
    assign out_blue  = byte10_reg[2];
    assign out_grey  = grey10_reg;

endmodule

// ----- rtl/theme_lightness_remap.sv -----
// top level: rgb to hsl, lightness remap against the theme, hsl back to rgb
// One pixel per beat, one result beat per pixel, and a new pixel can enter on every clock
// while the output beat is not held. The datapath is a single stall-enabled pipeline of
// 2*FRAC_BITS + 12 register stages: two stages find max, min and the hue numerator, a pair of
// FRAC_BITS+1 stage restoring dividers computes saturation and hue in parallel while the
// lightness, taken by a reciprocal multiply, rides along in the divider tag, two stages pick
// the remap branch and form its product, a second divider of the same depth gives the
// remapped lightness, one stage finishes it, and five stages turn hsl back into saturated
// bytes. The dividers set the latency. When the result beat is held by m_ready low, the
// whole pipeline freezes and s_ready drops in the same cycle. Configuration writes are
// always taken (cfg_ready is tied high); they should only be issued while no pixel is in
// flight, since the remap stage reads the registers live.
`include "assert_macros.svh"

module theme_lightness_remap (
    input  logic                               aclk,
    input  logic                               aresetn,
    // pixel input
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [7:0]                         s_in_red,
    input  logic [7:0]                         s_in_green,
    input  logic [7:0]                         s_in_blue,
    // pixel output
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [7:0]                         m_out_red,
    output logic [7:0]                         m_out_green,
    output logic [7:0]                         m_out_blue,
    // register writes
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [thlr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [15:0]                        cfg_data
);

    localparam int QW   = thlr_pkg::QW;
    localparam int NUMW = thlr_pkg::NUMW;
    localparam int F    = thlr_pkg::FRAC_BITS;
    localparam int LPW  = thlr_pkg::RECIP_W + 9;

    // theme and halo registers
    logic [15:0] theme_reg;
    logic [15:0] halo_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            theme_reg <= thlr_pkg::THEME_RESET;
            halo_reg  <= thlr_pkg::HALO_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                thlr_pkg::CFG_THEME: theme_reg <= cfg_data;
                thlr_pkg::CFG_HALO:  halo_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // global stage enable: everything moves unless the output beat is held
    logic ce;
    assign ce      = !m_valid || m_ready;
    assign s_ready = ce;

    // stage 1: captured input beat
    logic       v1_reg;
    logic [7:0] r1_reg, g1_reg, b1_reg;

    // stage 2: max/min analysis
    logic        v2_reg;
    logic [8:0]  sum2_reg, sden2_reg;
    logic [7:0]  d2_reg;
    logic [10:0] n2_reg, d6_2_reg;
    logic        grey2_reg;

    logic [7:0]         mx, mn, dd;
    logic [8:0]         sum_next, sden_next;
    logic [10:0]        d6_next;
    logic signed [11:0] n_s;

    always_comb begin
        mx = r1_reg;
        mn = r1_reg;
        if (g1_reg > mx) mx = g1_reg;
        if (b1_reg > mx) mx = b1_reg;
        if (g1_reg < mn) mn = g1_reg;
        if (b1_reg < mn) mn = b1_reg;
        dd       = mx - mn;
        sum_next = 9'(mx) + 9'(mn);
        // saturation denominator folds around mid lightness
        sden_next = (sum_next > 9'd255) ? (9'(thlr_pkg::LIGHT_DEN) - sum_next) : sum_next;
        d6_next   = 11'(dd) * 11'd6;
        // hue numerator, sector chosen by the dominant channel
        if (r1_reg > g1_reg && r1_reg > b1_reg) begin
            n_s = $signed({4'b0, g1_reg}) - $signed({4'b0, b1_reg})
                + ((g1_reg < b1_reg) ? $signed({1'b0, d6_next}) : 12'sd0);
        end else if (g1_reg > b1_reg) begin
            n_s = $signed({4'b0, b1_reg}) - $signed({4'b0, r1_reg})
                + $signed({3'b0, dd, 1'b0});
        end else begin
            n_s = $signed({4'b0, r1_reg}) - $signed({4'b0, g1_reg})
                + $signed({2'b0, dd, 2'b0});
        end
    end

    // lightness: (mx + mn) / 510 by reciprocal multiply, carried in the divider tag
    logic [LPW-1:0] light_prod;
    logic [QW-1:0]  light_a;

    assign light_prod = LPW'(sum2_reg) * LPW'(thlr_pkg::LIGHT_RECIP);
    assign light_a    = light_prod[thlr_pkg::LIGHT_SH +: QW];

    // dividers: saturation, hue
    thlr_pkg::tag_t tag_a_in;
    logic           va_s, va_h;
    logic [QW-1:0]  l_a, s_a, h_a;
    thlr_pkg::tag_t tag_s, tag_h;

    always_comb begin
        tag_a_in       = '0;
        tag_a_in.grey  = grey2_reg;
        tag_a_in.light = light_a;
    end

    thlr_div u_div_sat (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ce       (ce),
        .in_valid (v2_reg),
        .in_num   (NUMW'(d2_reg) << F),
        .in_den   (QW'(sden2_reg)),
        .in_tag   (tag_a_in),
        .out_valid(va_s),
        .out_quot (s_a),
        .out_tag  (tag_s)
    );

    thlr_div u_div_hue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ce       (ce),
        .in_valid (v2_reg),
        .in_num   (NUMW'(n2_reg) << F),
        .in_den   (QW'(d6_2_reg)),
        .in_tag   (tag_a_in),
        .out_valid(va_h),
        .out_quot (h_a),
        .out_tag  (tag_h)
    );

    assign l_a = tag_s.light;

    // stage 3: dark theme flip and remap branch choice
    logic           v3_reg;
    logic [QW-1:0]  a3_reg, b3_reg, den3_reg;
    thlr_pkg::tag_t tag3_reg;

    logic [QW-1:0]  t_fx, k_raw, k_eff, l_eff, a_next, b_next, den_next;
    logic           dark, upper_next;
    thlr_pkg::tag_t tag3_next;

    always_comb begin
        t_fx       = thlr_pkg::q16_to_fx(theme_reg);
        k_raw      = thlr_pkg::q16_to_fx(halo_reg);
        dark       = !theme_reg[15];
        k_eff      = dark ? (thlr_pkg::FX_ONE - k_raw) : k_raw;
        l_eff      = dark ? (thlr_pkg::FX_ONE - l_a) : l_a;
        upper_next = !(l_eff < k_eff);
        if (upper_next) begin
            // scale the distance to full white
            a_next   = thlr_pkg::FX_ONE - t_fx;
            b_next   = thlr_pkg::FX_ONE - l_eff;
            den_next = thlr_pkg::FX_ONE - k_eff;
        end else begin
            // scale from black toward the background
            a_next   = t_fx;
            b_next   = l_eff;
            den_next = k_eff;
        end
        tag3_next       = '0;
        tag3_next.grey  = tag_s.grey;
        tag3_next.upper = upper_next;
        tag3_next.kfull = (k_eff >= thlr_pkg::FX_ONE);
        tag3_next.sat   = s_a;
        tag3_next.hue   = h_a;
    end

    // stage 4: remap numerator product
    logic           v4_reg;
    logic [NUMW-1:0] prod4_reg;
    logic [QW-1:0]  den4_reg;
    thlr_pkg::tag_t tag4_reg;

    // remap divider
    logic           vb;
    logic [QW-1:0]  qb;
    thlr_pkg::tag_t tagb;

    thlr_div u_div_remap (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ce       (ce),
        .in_valid (v4_reg),
        .in_num   (prod4_reg),
        .in_den   (den4_reg),
        .in_tag   (tag4_reg),
        .out_valid(vb),
        .out_quot (qb),
        .out_tag  (tagb)
    );

    // stage 5: remapped lightness; a full-scale effective halo pins the upper branch to white
    logic           v5_reg;
    thlr_pkg::pix_t pix5_reg, pix5_next;

    always_comb begin
        pix5_next.grey = tagb.grey;
        pix5_next.sat  = tagb.sat;
        pix5_next.hue  = tagb.hue;
        if (tagb.upper) begin
            pix5_next.nl = tagb.kfull ? thlr_pkg::FX_ONE : (thlr_pkg::FX_ONE - qb);
        end else begin
            pix5_next.nl = qb;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else if (ce) begin
            v1_reg <= s_valid;
            v2_reg <= v1_reg;
            v3_reg <= va_s;
            v4_reg <= v3_reg;
            v5_reg <= vb;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            r1_reg    <= s_in_red;
            g1_reg    <= s_in_green;
            b1_reg    <= s_in_blue;

            sum2_reg  <= sum_next;
            sden2_reg <= sden_next;
            d2_reg    <= dd;
            n2_reg    <= n_s[10:0];
            d6_2_reg  <= d6_next;
            grey2_reg <= (dd == 8'd0);

            a3_reg    <= a_next;
            b3_reg    <= b_next;
            den3_reg  <= den_next;
            tag3_reg  <= tag3_next;

            prod4_reg <= NUMW'(a3_reg) * NUMW'(b3_reg);
            den4_reg  <= den3_reg;
            tag4_reg  <= tag3_reg;

            pix5_reg  <= pix5_next;
        end
    end

    // stages 6 to 10: back to rgb
    logic out_grey;

    thlr_rgb_out u_rgb_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ce       (ce),
        .in_valid (v5_reg),
        .in_pix   (pix5_reg),
        .out_valid(m_valid),
        .out_red  (m_out_red),
        .out_green(m_out_green),
        .out_blue (m_out_blue),
        .out_grey (out_grey)
    );

    // grey pixels leave with all three channels equal
    `ASSERT_CLKD(a_grey_equal, m_valid && out_grey |-> (m_out_red == m_out_green) && (m_out_green == m_out_blue), "grey pixel with unequal channels")
    // the two parallel dividers stay in lockstep
    `ASSERT_CLKD(a_div_lockstep, (va_s == va_h) && (!va_s || (tag_s.grey == tag_h.grey)), "parallel dividers out of step")
    // remapped lightness never exceeds full scale
    `ASSERT_CLKD(a_nl_range, v5_reg |-> (pix5_reg.nl <= thlr_pkg::FX_ONE), "remapped lightness above one")

endmodule
